@@ design/pmc_pkg.sv @@
`default_nettype none

package pmc_pkg;

    // Field widths of one transaction on each channel.
    localparam int KIND_W     = 2;
    localparam int REG_NUM_W  = 4;
    localparam int REG_SUB_W  = 4;
    localparam int OPCODE_W   = 3;
    localparam int DATA_W     = 32;
    localparam int EVENT_W    = 8;
    localparam int CW_W       = 28;

    // Counters with storage, and the number of them that count events.
    localparam int EVENT_COUNTERS    = 2;
    localparam int COUNTER_SLOTS     = 2;
    localparam int COUNTING_COUNTERS =
        (EVENT_COUNTERS > COUNTER_SLOTS) ? COUNTER_SLOTS : EVENT_COUNTERS;

    // Control word bit positions.
    localparam int CW_E        = 0;
    localparam int CW_P        = 1;
    localparam int CW_C        = 2;
    localparam int CW_D        = 3;
    localparam int CW_INTEN_LO = 4;
    localparam int CW_FLAG_LO  = 8;
    localparam int CW_FLAG_CYC = 10;
    localparam int CW_SEL_LO   = 12;
    localparam int CW_FIELD3_W = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK  = 2'd0,
        KIND_EVENT = 2'd1,
        KIND_READ  = 2'd2,
        KIND_WRITE = 2'd3
    } kind_t;

    // Register map.
    localparam logic [REG_NUM_W-1:0] REG_CONTROL = 4'd0;
    localparam logic [REG_NUM_W-1:0] REG_CYCLE   = 4'd1;
    localparam logic [REG_NUM_W-1:0] REG_EVENT0  = 4'd2;
    localparam logic [REG_NUM_W-1:0] REG_EVENT1  = 4'd3;
    localparam logic [REG_NUM_W-1:0] REG_CLKCFG  = 4'd6;
    localparam logic [REG_NUM_W-1:0] REG_PWRMODE = 4'd7;

    typedef struct packed {
        kind_t                kind;
        logic [REG_NUM_W-1:0] reg_number;
        logic [REG_SUB_W-1:0] reg_sub;
        logic [OPCODE_W-1:0]  opcode_one;
        logic [OPCODE_W-1:0]  opcode_two;
        logic                 alt_form;
        logic [DATA_W-1:0]    write_data;
        logic [EVENT_W-1:0]   event_number;
    } pmc_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              accepted;
        logic              pmu_irq;
    } pmc_result_t;

endpackage

`default_nettype wire

@@ design/pmc_if.sv @@
`default_nettype none

interface pmc_item_if
    import pmc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [REG_NUM_W-1:0] reg_number;
    logic [REG_SUB_W-1:0] reg_sub;
    logic [OPCODE_W-1:0]  opcode_one;
    logic [OPCODE_W-1:0]  opcode_two;
    logic                 alt_form;
    logic [DATA_W-1:0]    write_data;
    logic [EVENT_W-1:0]   event_number;

    modport source (
        output valid, kind, reg_number, reg_sub, opcode_one, opcode_two,
               alt_form, write_data, event_number,
        input  ready
    );

    modport sink (
        input  valid, kind, reg_number, reg_sub, opcode_one, opcode_two,
               alt_form, write_data, event_number,
        output ready
    );
endinterface

interface pmc_result_if
    import pmc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              accepted;
    logic              pmu_irq;

    modport source (
        output valid, read_data, accepted, pmu_irq,
        input  ready
    );

    modport sink (
        input  valid, read_data, accepted, pmu_irq,
        output ready
    );
endinterface

`default_nettype wire

@@ design/pmc_exec.sv @@
`default_nettype none

module pmc_exec
    import pmc_pkg::*;
#(
    parameter int DIVIDER_BITS = 6
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        fire,
    input  wire pmc_item_t   item,
    output pmc_result_t      result
);

    logic [CW_W-1:0]         cw_reg,    cw_next;
    logic [DATA_W-1:0]       cyc_reg,   cyc_next;
    logic [DATA_W-1:0]       ev_reg  [COUNTER_SLOTS];
    logic [DATA_W-1:0]       ev_next [COUNTER_SLOTS];
    logic [DIVIDER_BITS-1:0] div_reg,   div_next;
    logic                    turbo_reg, turbo_next;

    logic                    enc_ok;
    logic                    is_read;

    assign enc_ok  = (item.reg_sub == '0) && (item.opcode_one == '0) &&
                     (item.opcode_two == '0) && !item.alt_form;
    assign is_read = (item.kind == KIND_READ);

    always_comb
    begin
        cw_next    = cw_reg;
        cyc_next   = cyc_reg;
        ev_next    = ev_reg;
        div_next   = div_reg;
        turbo_next = turbo_reg;
        result     = '0;

        unique case (item.kind)
            KIND_TICK:
            begin
                if (cw_reg[CW_E])
                begin
                    div_next = div_reg + 1'b1;
                    if (!cw_reg[CW_D] || (div_next == '0))
                    begin
                        cyc_next = cyc_reg + 1'b1;
                        if (cyc_next == '0)
                        begin
                            cw_next[CW_FLAG_CYC] = 1'b1;
                        end
                    end
                end
            end
            KIND_EVENT:
            begin
                for (int i = 0; i < COUNTING_COUNTERS; i++)
                begin
                    if (cw_reg[CW_E] &&
                        (cw_reg[CW_SEL_LO + EVENT_W*i +: EVENT_W] == item.event_number))
                    begin
                        ev_next[i] = ev_reg[i] + 1'b1;
                        if (ev_next[i] == '0)
                        begin
                            cw_next[CW_FLAG_LO + i] = 1'b1;
                        end
                    end
                end
            end
            KIND_READ, KIND_WRITE:
            begin
                if (enc_ok)
                begin
                    result.accepted = 1'b1;
                    unique case (item.reg_number)
                        REG_CONTROL:
                        begin
                            if (is_read)
                            begin
                                result.read_data = {{(DATA_W-CW_W){1'b0}}, cw_reg};
                            end
                            else
                            begin
                                if (item.write_data[CW_E] && !cw_reg[CW_E])
                                begin
                                    div_next = '0;
                                end
                                if (item.write_data[CW_P])
                                begin
                                    for (int i = 0; i < COUNTER_SLOTS; i++)
                                    begin
                                        ev_next[i] = '0;
                                    end
                                end
                                if (item.write_data[CW_C])
                                begin
                                    cyc_next = '0;
                                end
                                // Flags are write-one-to-clear; enable, divider, the
                                // interrupt enables and the selectors load from the data.
                                cw_next = '0;
                                cw_next[CW_E] = item.write_data[CW_E];
                                cw_next[CW_D] = item.write_data[CW_D];
                                cw_next[CW_INTEN_LO +: CW_FIELD3_W] =
                                    item.write_data[CW_INTEN_LO +: CW_FIELD3_W];
                                cw_next[CW_FLAG_LO +: CW_FIELD3_W] =
                                    cw_reg[CW_FLAG_LO +: CW_FIELD3_W] &
                                    ~item.write_data[CW_FLAG_LO +: CW_FIELD3_W];
                                cw_next[CW_W-1:CW_SEL_LO] =
                                    item.write_data[CW_W-1:CW_SEL_LO];
                            end
                        end
                        REG_CYCLE:
                        begin
                            if (is_read) result.read_data = cyc_reg;
                            else         cyc_next = item.write_data;
                        end
                        REG_EVENT0:
                        begin
                            if (is_read) result.read_data = ev_reg[0];
                            else         ev_next[0] = item.write_data;
                        end
                        REG_EVENT1:
                        begin
                            if (is_read) result.read_data = ev_reg[1];
                            else         ev_next[1] = item.write_data;
                        end
                        REG_CLKCFG:
                        begin
                            if (!is_read) turbo_next = item.write_data[0];
                        end
                        REG_PWRMODE:
                        begin
                            if (is_read)
                            begin
                                result.read_data = {{(DATA_W-1){1'b0}}, turbo_reg};
                            end
                        end
                        default:
                        begin
                            result.accepted = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                result.accepted = 1'b0;
            end
        endcase

        result.pmu_irq = |(cw_next[CW_INTEN_LO +: CW_FIELD3_W] &
                           cw_next[CW_FLAG_LO +: CW_FIELD3_W]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cw_reg    <= '0;
            cyc_reg   <= '0;
            div_reg   <= '0;
            turbo_reg <= 1'b0;
            for (int i = 0; i < COUNTER_SLOTS; i++)
            begin
                ev_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            cw_reg    <= cw_next;
            cyc_reg   <= cyc_next;
            div_reg   <= div_next;
            turbo_reg <= turbo_next;
            ev_reg    <= ev_next;
        end
    end

endmodule

`default_nettype wire

@@ design/pmc_out_buf.sv @@
`default_nettype none

module pmc_out_buf
    import pmc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire pmc_result_t push_data,
    output logic             room,
    pmc_result_if.source     result
);

    // Two-entry queue: the head drives the port, the second entry
    // catches a transaction while the head is stalled.
    logic [1:0]  count_reg, count_next;
    pmc_result_t head_reg, head_next;
    pmc_result_t tail_reg, tail_next;
    logic        pop;

    assign room             = (count_reg != 2'd2);
    assign pop              = result.valid && result.ready;
    assign result.valid     = (count_reg != 2'd0);
    assign result.read_data = head_reg.read_data;
    assign result.accepted  = head_reg.accepted;
    assign result.pmu_irq   = head_reg.pmu_irq;

    always_comb
    begin
        count_next = count_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        priority if (push && pop)
        begin
            if (count_reg == 2'd1)
            begin
                head_next = push_data;
            end
            else
            begin
                head_next = tail_reg;
                tail_next = push_data;
            end
        end
        else if (push)
        begin
            if (count_reg == 2'd0) head_next = push_data;
            else                   tail_next = push_data;
            count_next = count_reg + 2'd1;
        end
        else if (pop)
        begin
            head_next  = tail_reg;
            count_next = count_reg - 2'd1;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

`default_nettype wire

@@ design/performance_monitor_counters_core.sv @@
`default_nettype none

// Channel   Modport  Direction  Payload
// item      sink     in         kind, reg_number, reg_sub, opcode_one,
//                               opcode_two, alt_form, write_data, event_number
// result    source   out        read_data, accepted, pmu_irq
//
// One transaction is accepted per cycle while item.ready is high, and every
// accepted transaction yields exactly one result transaction, after passing
// through the input register and then the result queue.
// Reset (rst_n low, asynchronous) clears the control word, all counters, the
// divider and the turbo bit, and empties both stages.
// A stalled result side fills the two-entry result queue; the input register
// then holds its transaction and item.ready drops until an entry frees up.

module performance_monitor_counters_core
    import pmc_pkg::*;
#(
    parameter int DIVIDER_BITS = 6
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    pmc_item_if.sink     item,
    pmc_result_if.source result
);

    // Input register. It advances into the execute step whenever the result
    // queue has a free entry, so back-to-back transactions stream through.
    logic        in_valid_reg, in_valid_next;
    pmc_item_t   in_item_reg;
    logic        in_accept;
    logic        fire;
    logic        room;
    pmc_result_t exec_result;

    assign fire       = in_valid_reg && room;
    assign item.ready = !in_valid_reg || room;
    assign in_accept  = item.valid && item.ready;

    always_comb
    begin
        priority if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_item_reg.kind         <= kind_t'(item.kind);
            in_item_reg.reg_number   <= item.reg_number;
            in_item_reg.reg_sub      <= item.reg_sub;
            in_item_reg.opcode_one   <= item.opcode_one;
            in_item_reg.opcode_two   <= item.opcode_two;
            in_item_reg.alt_form     <= item.alt_form;
            in_item_reg.write_data   <= item.write_data;
            in_item_reg.event_number <= item.event_number;
        end
    end

    // Execute step: decodes the transaction, updates the counters and the
    // register file, and forms the result in the same cycle.
    pmc_exec #(
        .DIVIDER_BITS (DIVIDER_BITS)
    ) u_exec (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_item_reg),
        .result (exec_result)
    );

    // Result register with a skid entry.
    pmc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .push_data (exec_result),
        .room      (room),
        .result    (result)
    );

endmodule

`default_nettype wire

@@ tb/performance_monitor_counters_core_tb.sv @@
`timescale 1ns / 100ps

// Self-checking bench for the performance monitor counter block.
// A stimulus process offers transactions on the item channel and predicts each
// accepted one in order. The predicted results are queued, and a monitor on
// the result channel compares every result transaction against the oldest
// prediction. A short table of directed transactions runs first. It covers
// reset values, unknown registers, bad encodings, the clock-config and
// power-mode registers, and counter wrap with interrupt. Random transactions
// follow it.

module performance_monitor_counters_core_tb;
    import pmc_pkg::*;

    localparam int DIV_BITS       = 6;
    localparam int RANDOM_ITEMS   = 450;
    localparam int HOLD_CYCLES    = 80;
    localparam int HOLD_AFTER     = 150;
    localparam int DRAIN_CYCLES   = 20;
    localparam int TIMEOUT_NS     = 2_000_000;

    // Control word masks built from the package bit positions.
    localparam logic [CW_W-1:0] FLAG_MASK = 28'd7 << CW_FLAG_LO;
    localparam logic [CW_W-1:0] LOAD_MASK = (28'd1 << CW_E) | (28'd1 << CW_D)
                                          | (28'd7 << CW_INTEN_LO)
                                          | (28'hFFFF << CW_SEL_LO);

    logic clk;
    logic rst_n;

    pmc_item_if   item_ch ();
    pmc_result_if result_ch ();

    performance_monitor_counters_core #(
        .DIVIDER_BITS(DIV_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    // One row of the directed table. When has_exp is set, the expected result
    // is the literal in the row. Otherwise the predictor supplies it.
    typedef struct {
        pmc_item_t   it;
        bit          has_exp;
        pmc_result_t exp;
    } directed_row_t;

    // Predicted state of the monitor.
    logic [CW_W-1:0]     ctrl_word;
    logic [DATA_W-1:0]   cycle_cnt;
    logic [DATA_W-1:0]   evt_cnt [COUNTER_SLOTS];
    logic [DIV_BITS-1:0] div_cnt;
    logic                turbo;

    pmc_result_t   pending_results [$];
    directed_row_t directed_rows [$];

    int  error_count    = 0;
    int  accepted_items = 0;
    int  result_count   = 0;
    int  burst_left     = 0;
    bit  hold_active    = 0;
    bit  pressure_done  = 0;
    int  n_ticks        = 0;
    int  n_events       = 0;
    int  n_reads        = 0;
    int  n_writes       = 0;
    int  n_access_ok    = 0;
    int  n_irq          = 0;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs or loses a result.
    initial
    begin
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

    // Works out the result of one transaction and advances the predicted state.
    // A tick or event result carries only the interrupt level. An access result
    // has accepted set when the encoding fields are all zero and the register
    // exists.
    function automatic pmc_result_t compute_pmu_result(input pmc_item_t it);
        pmc_result_t       r;
        logic              enc_ok;
        logic              is_read;
        logic [DATA_W-1:0] wd;
        r       = '0;
        enc_ok  = (it.reg_sub == '0) && (it.opcode_one == '0)
               && (it.opcode_two == '0) && !it.alt_form;
        is_read = (it.kind == KIND_READ);
        wd      = it.write_data;
        case (it.kind)
            KIND_TICK:
            begin
                if (ctrl_word[CW_E])
                begin
                    // With the divider on, only the tick that brings the
                    // prescaler back to zero advances the cycle counter.
                    div_cnt = div_cnt + 1'b1;
                    if (!ctrl_word[CW_D] || div_cnt == '0)
                    begin
                        cycle_cnt = cycle_cnt + 32'd1;
                        if (cycle_cnt == '0)
                            ctrl_word[CW_FLAG_CYC] = 1'b1;
                    end
                end
            end
            KIND_EVENT:
            begin
                // Both counters are checked, so equal selectors count twice.
                if (ctrl_word[CW_E])
                begin
                    for (int i = 0; i < COUNTING_COUNTERS; i++)
                    begin
                        if (ctrl_word[CW_SEL_LO + EVENT_W * i +: EVENT_W]
                            == it.event_number)
                        begin
                            evt_cnt[i] = evt_cnt[i] + 32'd1;
                            if (evt_cnt[i] == '0)
                                ctrl_word[CW_FLAG_LO + i] = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                if (enc_ok)
                begin
                    r.accepted = 1'b1;
                    case (it.reg_number)
                        REG_CONTROL:
                        begin
                            if (is_read)
                                r.read_data = DATA_W'(ctrl_word);
                            else
                            begin
                                // The prescaler restarts only when enable goes
                                // from off to on. Bits 1 and 2 are one-shot
                                // clears, and flags are cleared by writing 1.
                                if (wd[CW_E] && !ctrl_word[CW_E])
                                    div_cnt = '0;
                                if (wd[CW_P])
                                begin
                                    evt_cnt[0] = '0;
                                    evt_cnt[1] = '0;
                                end
                                if (wd[CW_C])
                                    cycle_cnt = '0;
                                ctrl_word = ctrl_word & ~(wd[CW_W-1:0] & FLAG_MASK);
                                ctrl_word = (ctrl_word & ~LOAD_MASK)
                                          | (wd[CW_W-1:0] & LOAD_MASK);
                            end
                        end
                        REG_CYCLE:
                        begin
                            if (is_read) r.read_data = cycle_cnt;
                            else         cycle_cnt = wd;
                        end
                        REG_EVENT0:
                        begin
                            if (is_read) r.read_data = evt_cnt[0];
                            else         evt_cnt[0] = wd;
                        end
                        REG_EVENT1:
                        begin
                            if (is_read) r.read_data = evt_cnt[1];
                            else         evt_cnt[1] = wd;
                        end
                        REG_CLKCFG:
                        begin
                            if (!is_read) turbo = wd[0];
                        end
                        REG_PWRMODE:
                        begin
                            if (is_read) r.read_data = DATA_W'(turbo);
                        end
                        default:
                            r.accepted = 1'b0;
                    endcase
                end
            end
        endcase
        r.pmu_irq = |(ctrl_word[CW_INTEN_LO +: CW_FIELD3_W]
                    & ctrl_word[CW_FLAG_LO +: CW_FIELD3_W]);
        return r;
    endfunction

    task automatic add_row(input kind_t k, input logic [REG_NUM_W-1:0] rn,
                           input logic [REG_SUB_W-1:0] sub,
                           input logic [OPCODE_W-1:0] op1,
                           input logic [OPCODE_W-1:0] op2, input logic alt,
                           input logic [DATA_W-1:0] wd,
                           input logic [EVENT_W-1:0] ev, input bit has,
                           input logic [DATA_W-1:0] rd, input logic acc,
                           input logic irq);
        directed_row_t row;
        row.it.kind         = k;
        row.it.reg_number   = rn;
        row.it.reg_sub      = sub;
        row.it.opcode_one   = op1;
        row.it.opcode_two   = op2;
        row.it.alt_form     = alt;
        row.it.write_data   = wd;
        row.it.event_number = ev;
        row.has_exp         = has;
        row.exp.read_data   = rd;
        row.exp.accepted    = acc;
        row.exp.pmu_irq     = irq;
        directed_rows.push_back(row);
    endtask

    // Builds a random transaction. Most accesses are well formed and go to
    // real registers. Control writes usually keep the monitor enabled. Counter
    // writes often land just below the wrap point. Events mostly hit a
    // selector, so counters overflow and the interrupt gets exercised.
    function automatic pmc_item_t make_random_item();
        pmc_item_t it;
        int        pick;
        it.reg_sub      = '0;
        it.opcode_one   = '0;
        it.opcode_two   = '0;
        it.alt_form     = 1'b0;
        it.write_data   = $urandom;
        it.event_number = EVENT_W'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 30)      it.kind = KIND_TICK;
        else if (pick < 55) it.kind = KIND_EVENT;
        else if (pick < 75) it.kind = KIND_READ;
        else                it.kind = KIND_WRITE;

        pick = $urandom_range(0, 19);
        case (pick)
            0, 1, 2, 3: it.reg_number = REG_CONTROL;
            4, 5, 6:    it.reg_number = REG_CYCLE;
            7, 8, 9:    it.reg_number = REG_EVENT0;
            10, 11, 12: it.reg_number = REG_EVENT1;
            13, 14:     it.reg_number = REG_CLKCFG;
            15, 16:     it.reg_number = REG_PWRMODE;
            default:    it.reg_number = REG_NUM_W'($urandom_range(0, 15));
        endcase

        // A noisy encoding field on about one access in ten.
        if ($urandom_range(0, 9) == 0)
        begin
            case ($urandom_range(0, 3))
                0:       it.reg_sub    = REG_SUB_W'($urandom_range(0, 15));
                1:       it.opcode_one = OPCODE_W'($urandom_range(0, 7));
                2:       it.opcode_two = OPCODE_W'($urandom_range(0, 7));
                default: it.alt_form   = 1'b1;
            endcase
        end

        if (it.kind == KIND_WRITE && it.reg_number == REG_CONTROL)
        begin
            it.write_data[CW_E] = ($urandom_range(0, 99) < 85);
            it.write_data[CW_P] = ($urandom_range(0, 99) < 15);
            it.write_data[CW_C] = ($urandom_range(0, 99) < 15);
            it.write_data[CW_D] = ($urandom_range(0, 99) < 30);
            if ($urandom_range(0, 3) == 0)
                it.write_data[CW_SEL_LO +: 2 * EVENT_W] =
                    16'($urandom_range(0, 3) * 16'h0101);
        end
        else if (it.kind == KIND_WRITE && $urandom_range(0, 99) < 40)
            it.write_data = 32'hFFFF_FFFF - $urandom_range(0, 40);

        if (it.kind == KIND_EVENT && $urandom_range(0, 99) < 70)
            it.event_number = ctrl_word[CW_SEL_LO + EVENT_W * $urandom_range(0, 1)
                                        +: EVENT_W];
        return it;
    endfunction

    // Presents one transaction and returns at the edge where it is accepted.
    task automatic offer_item(input pmc_item_t it);
        item_ch.valid        <= 1'b1;
        item_ch.kind         <= it.kind;
        item_ch.reg_number   <= it.reg_number;
        item_ch.reg_sub      <= it.reg_sub;
        item_ch.opcode_one   <= it.opcode_one;
        item_ch.opcode_two   <= it.opcode_two;
        item_ch.alt_form     <= it.alt_form;
        item_ch.write_data   <= it.write_data;
        item_ch.event_number <= it.event_number;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
    endtask

    // Sends one transaction, predicts it and queues the expected result. The
    // sender then either continues its burst or idles before a new burst. It
    // never idles while the result side is being held off.
    task automatic issue_item(input pmc_item_t it, input bit has_exp,
                              input pmc_result_t typed_exp);
        pmc_result_t predicted;
        offer_item(it);
        predicted = compute_pmu_result(it);
        pending_results.push_back(has_exp ? typed_exp : predicted);
        accepted_items++;
        case (it.kind)
            KIND_TICK:  n_ticks++;
            KIND_EVENT: n_events++;
            KIND_READ:  n_reads++;
            default:    n_writes++;
        endcase
        if (predicted.accepted) n_access_ok++;
        if (predicted.pmu_irq)  n_irq++;

        if (burst_left > 0 || hold_active)
            burst_left--;
        else
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 10);
        end
    endtask

    // Stimulus: reset, the directed table, random traffic, then drain.
    initial
    begin
        pmc_item_t   it;
        pmc_result_t none;
        none = '0;
        rst_n                <= 1'b0;
        item_ch.valid        <= 1'b0;
        item_ch.kind         <= '0;
        item_ch.reg_number   <= '0;
        item_ch.reg_sub      <= '0;
        item_ch.opcode_one   <= '0;
        item_ch.opcode_two   <= '0;
        item_ch.alt_form     <= 1'b0;
        item_ch.write_data   <= '0;
        item_ch.event_number <= '0;
        ctrl_word  = '0;
        cycle_cnt  = '0;
        evt_cnt[0] = '0;
        evt_cnt[1] = '0;
        div_cnt    = '0;
        turbo      = 1'b0;

        // Reset values, then a tick and an event while the monitor is disabled.
        add_row(KIND_READ,  REG_CONTROL, 0, 0, 0, 0, 0, 0, 1, 0, 1, 0);
        add_row(KIND_READ,  REG_CYCLE,   0, 0, 0, 0, 0, 0, 1, 0, 1, 0);
        add_row(KIND_TICK,  0,           0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
        add_row(KIND_EVENT, 0,           0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
        add_row(KIND_READ,  REG_EVENT0,  0, 0, 0, 0, 0, 0, 1, 0, 1, 0);
        // Holes in the register map and every bad encoding field.
        add_row(KIND_WRITE, 4'd4,  0, 0, 0, 0, 32'hFFFF_FFFF, 0, 1, 0, 0, 0);
        add_row(KIND_READ,  4'd5,  0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
        add_row(KIND_READ,  4'd15, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
        add_row(KIND_READ,  REG_CONTROL, 4'hF, 0, 0, 0, 0, 0, 1, 0, 0, 0);
        add_row(KIND_READ,  REG_CONTROL, 0, 3'h7, 0, 0, 0, 0, 1, 0, 0, 0);
        add_row(KIND_READ,  REG_CONTROL, 0, 0, 3'h7, 0, 0, 0, 1, 0, 0, 0);
        add_row(KIND_WRITE, REG_CONTROL, 0, 0, 0, 1, 32'hFFFF_FFFF, 8'hFF,
                1, 0, 0, 0);
        // The turbo bit sits behind clock config and reads back via power mode.
        add_row(KIND_WRITE, REG_CLKCFG,  0, 0, 0, 0, 32'hFFFF_FFFF, 0, 1, 0, 1, 0);
        add_row(KIND_READ,  REG_PWRMODE, 0, 0, 0, 0, 0, 0, 1, 1, 1, 0);
        add_row(KIND_READ,  REG_CLKCFG,  0, 0, 0, 0, 0, 0, 1, 0, 1, 0);
        add_row(KIND_WRITE, REG_PWRMODE, 0, 0, 0, 0, 0, 0, 1, 0, 1, 0);
        // Preload the counters at the edge of wrapping, then enable all
        // interrupts with both selectors on the same event.
        add_row(KIND_WRITE, REG_CYCLE,   0, 0, 0, 0, 32'hFFFF_FFFF, 0, 1, 0, 1, 0);
        add_row(KIND_WRITE, REG_EVENT0,  0, 0, 0, 0, 32'hFFFF_FFFF, 0, 1, 0, 1, 0);
        add_row(KIND_WRITE, REG_EVENT1,  0, 0, 0, 0, 32'hFFFF_FFFE, 0, 1, 0, 1, 0);
        add_row(KIND_WRITE, REG_CONTROL, 0, 0, 0, 0, 32'h0ABA_B071, 0, 0, 0, 0, 0);
        add_row(KIND_TICK,  0, 0, 0, 0, 0, 0, 0,     0, 0, 0, 0);
        add_row(KIND_EVENT, 0, 0, 0, 0, 0, 0, 8'hAB, 0, 0, 0, 0);
        add_row(KIND_EVENT, 0, 0, 0, 0, 0, 0, 8'hAB, 0, 0, 0, 0);
        add_row(KIND_READ,  REG_CONTROL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        // An all-ones control write clears the counters and flags, sets the divider and
        // moves both selectors to 0xFF.
        add_row(KIND_WRITE, REG_CONTROL, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
        add_row(KIND_READ,  REG_CONTROL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            issue_item(directed_rows[i].it, directed_rows[i].has_exp,
                       directed_rows[i].exp);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            it = make_random_item();
            issue_item(it, 1'b0, none);
        end

        item_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d transactions (%0d ticks, %0d events, %0d reads, %0d writes).",
                 accepted_items, n_ticks, n_events, n_reads, n_writes);
        $display("%0d accesses were accepted and %0d results carried the interrupt.",
                 n_access_ok, n_irq);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Result side: the receiver changes its stall pattern after each run of
    // random length: always ready, mostly ready, alternating, or mostly stalled.
    // Once, after a good part of the traffic, it holds off for a long
    // stretch. The result queue then fills and the item side must stall.
    initial
    begin
        int mode;
        int len;
        bit toggle;
        toggle = 1'b0;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(5, 40);
            repeat (len)
            begin
                if (!pressure_done && accepted_items >= HOLD_AFTER)
                begin
                    hold_active = 1'b1;
                    result_ch.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    hold_active   = 1'b0;
                    pressure_done = 1'b1;
                end
                toggle = ~toggle;
                case (mode)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= ($urandom_range(0, 99) < 70);
                    2:       result_ch.ready <= toggle;
                    default: result_ch.ready <= ($urandom_range(0, 99) < 25);
                endcase
                @(posedge clk);
            end
        end
    end

    // Compare each result transaction with the oldest prediction.
    pmc_result_t oldest;

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            result_count++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction: read_data %h accepted %b irq %b",
                       result_ch.read_data, result_ch.accepted, result_ch.pmu_irq);
                error_count++;
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (result_ch.read_data !== oldest.read_data)
                begin
                    $error("read_data: expected %h, actual %h",
                           oldest.read_data, result_ch.read_data);
                    error_count++;
                end
                if (result_ch.accepted !== oldest.accepted)
                begin
                    $error("accepted: expected %b, actual %b",
                           oldest.accepted, result_ch.accepted);
                    error_count++;
                end
                if (result_ch.pmu_irq !== oldest.pmu_irq)
                begin
                    $error("pmu_irq: expected %b, actual %b",
                           oldest.pmu_irq, result_ch.pmu_irq);
                    error_count++;
                end
            end
        end
    end

endmodule
